@@ rtl/dsvbd_pkg.sv @@
`default_nettype none

package dsvbd_pkg;

    // Capacity of one block in items
    localparam int MAX_ITEMS = 256;

    // Four two-bit length codes per control byte
    localparam int CTRL_DEPTH = (MAX_ITEMS + 3) / 4;

    // Index widths
    localparam int IDX_W   = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CTRL_AW = (CTRL_DEPTH > 1) ? $clog2(CTRL_DEPTH) : 1;

    // Header: item count (2 bytes) and docid offset (2 bytes)
    localparam int HEADER_BYTES = 4;

    // Stored per item: new-run mark above the absolute hash
    localparam int STORE_W = 33;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_HCTRL  = 3'd2,
        PH_HDATA  = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DCTRL  = 3'd5,
        PH_DDATA  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_PAIR   = 2'd0,
        ST_OFFSET = 2'd1,
        ST_COUNT  = 2'd2
    } t_status;

endpackage

`default_nettype wire

@@ rtl/dsvbd_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
module dsvbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/delta_stream_vbyte_block_decoder.sv @@
`default_nettype none

// Channel   Handshake                     Beat
// -------   ---------------------------   ----------------------------------------
// in        i_in_valid / o_in_ready       i_block_byte, i_block_start
// out       o_out_valid / i_out_ready     o_hash_value, o_doc_id, o_last_item, o_status
// cfg       i_cfg_we (no wait)            i_cfg_data -> base_doc_id
//
// One byte is taken per cycle; each byte passes the decode logic once, between the
// state registers and the result register, so a result is registered in the cycle after its byte.
// Length codes and per-item hashes sit in registered-read RAMs whose read address is
// steered by the next item index, so one-byte values can follow each other directly.
// The input stalls only while a result waits and the output is not ready.
// Reset is synchronous, active low; the stores need no clearing.
module delta_stream_vbyte_block_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_block_byte,
    input  wire logic        i_block_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_hash_value,
    output logic [31:0]      o_doc_id,
    output logic             o_last_item,
    output logic [1:0]       o_status
);

    localparam int IW = dsvbd_pkg::IDX_W;
    localparam int AW = dsvbd_pkg::ADDR_W;
    localparam int CW = dsvbd_pkg::CTRL_AW;
    localparam int SW = dsvbd_pkg::STORE_W;

    // State registers
    dsvbd_pkg::t_phase r_phase, n_phase;
    logic [15:0]       r_pos, n_pos;
    logic [15:0]       r_total, n_total;
    logic [15:0]       r_dstart, n_dstart;
    logic [IW-1:0]     r_idx, n_idx;
    logic [1:0]        r_biv, n_biv;
    logic [23:0]       r_acc, n_acc;
    logic [31:0]       r_hash, n_hash;
    logic [31:0]       r_doc, n_doc;
    logic [7:0]        r_ctrl, n_ctrl;
    logic [31:0]       r_base;

    // Result register
    logic              r_out_valid;
    logic [31:0]       r_out_hash;
    logic [31:0]       r_out_doc;
    logic              r_out_last;
    dsvbd_pkg::t_status r_out_status;

    // Per-beat decode signals
    logic               in_acc;
    dsvbd_pkg::t_phase  c_phase;
    logic [15:0]        c_pos, c_total, c_dstart, pos_inc, ctrl_k;
    logic [16:0]        ctrl_cnt;
    logic [1:0]         cur_code;
    logic               val_done;
    logic [31:0]        val, h_sum;
    logic [IW-1:0]      idx_inc;
    logic               emit, e_last;
    logic [31:0]        e_hash, e_doc;
    dsvbd_pkg::t_status e_status;

    // RAM ports
    logic               cw_en, sw_en;
    logic [CW-1:0]      ctrl_raddr;
    logic [7:0]         ctrl_q;
    logic [AW-1:0]      store_raddr;
    logic [SW-1:0]      store_q;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Length code of the current item, value assembly
    assign cur_code = 2'(r_ctrl >> {r_idx[1:0], 1'b0});
    assign val_done = (r_biv >= cur_code);
    assign val      = {8'h00, r_acc} | (32'(i_block_byte) << {r_biv, 3'b000});
    assign h_sum    = r_hash + val;
    assign idx_inc  = r_idx + IW'(1);

    // A block start restarts the header
    assign c_phase  = i_block_start ? dsvbd_pkg::PH_HEADER : r_phase;
    assign c_pos    = i_block_start ? 16'd0 : r_pos;
    assign c_total  = i_block_start ? 16'd0 : r_total;
    assign c_dstart = i_block_start ? 16'd0 : r_dstart;
    assign pos_inc  = c_pos + 16'd1;

    // Control byte index within the current stream
    assign ctrl_k   = (c_phase == dsvbd_pkg::PH_HCTRL)
                      ? c_pos - 16'(dsvbd_pkg::HEADER_BYTES) : c_pos - c_dstart;
    assign ctrl_cnt = (17'(r_total) + 17'd3) >> 2;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dsvbd_pkg::PH_IDLE;
            r_pos    <= '0;
            r_total  <= '0;
            r_dstart <= '0;
            r_idx    <= '0;
            r_biv    <= '0;
            r_acc    <= '0;
            r_hash   <= '0;
            r_doc    <= '0;
            r_base   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_dstart <= n_dstart;
            r_idx    <= n_idx;
            r_biv    <= n_biv;
            r_acc    <= n_acc;
            r_hash   <= n_hash;
            r_doc    <= n_doc;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl <= n_ctrl;
    end

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_total  = r_total;
        n_dstart = r_dstart;
        n_idx    = r_idx;
        n_biv    = r_biv;
        n_acc    = r_acc;
        n_hash   = r_hash;
        n_doc    = r_doc;
        n_ctrl   = r_ctrl;
        emit     = 1'b0;
        e_hash   = '0;
        e_doc    = '0;
        e_last   = 1'b0;
        e_status = dsvbd_pkg::ST_PAIR;
        cw_en    = 1'b0;
        sw_en    = 1'b0;

        if (in_acc) begin
            if (i_block_start) begin
                n_phase  = dsvbd_pkg::PH_HEADER;
                n_pos    = '0;
                n_total  = '0;
                n_dstart = '0;
                n_idx    = '0;
                n_biv    = '0;
                n_acc    = '0;
                n_hash   = '0;
                n_doc    = '0;
            end

            unique case (c_phase) inside
                dsvbd_pkg::PH_IDLE: begin
                    // stray bytes between blocks are dropped
                end

                dsvbd_pkg::PH_HEADER: begin
                    n_pos = pos_inc;
                    if (c_pos == 16'd0) begin
                        n_total = {8'h00, i_block_byte};
                    end else if (c_pos == 16'd1) begin
                        n_total = {i_block_byte, c_total[7:0]};
                    end else if (c_pos == 16'd2) begin
                        n_dstart = {8'h00, i_block_byte};
                    end else begin
                        n_dstart = {i_block_byte, c_dstart[7:0]};
                        if (c_total > 16'(dsvbd_pkg::MAX_ITEMS)) begin
                            n_phase  = dsvbd_pkg::PH_IDLE;
                            emit     = 1'b1;
                            e_last   = 1'b1;
                            e_status = dsvbd_pkg::ST_COUNT;
                        end else if (c_total == 16'd0) begin
                            n_phase = dsvbd_pkg::PH_IDLE;
                        end else begin
                            n_phase = dsvbd_pkg::PH_HCTRL;
                        end
                    end
                end

                dsvbd_pkg::PH_HCTRL, dsvbd_pkg::PH_DCTRL: begin
                    n_pos = pos_inc;
                    cw_en = (ctrl_k < 16'(dsvbd_pkg::CTRL_DEPTH));
                    // first control byte goes straight to the code register
                    if (ctrl_k == 16'd0) begin
                        n_ctrl = i_block_byte;
                    end
                    if ({1'b0, ctrl_k} + 17'd1 >= ctrl_cnt) begin
                        n_phase = (c_phase == dsvbd_pkg::PH_HCTRL)
                                  ? dsvbd_pkg::PH_HDATA : dsvbd_pkg::PH_DDATA;
                        n_idx   = '0;
                    end
                end

                dsvbd_pkg::PH_HDATA: begin
                    n_pos = pos_inc;
                    if (!val_done) begin
                        n_acc = val[23:0];
                        n_biv = r_biv + 2'd1;
                    end else begin
                        n_acc  = '0;
                        n_biv  = '0;
                        n_hash = h_sum;
                        sw_en  = 1'b1;
                        n_idx  = idx_inc;
                        if (r_idx[1:0] == 2'd3) begin
                            n_ctrl = ctrl_q;
                        end
                        if (16'(idx_inc) >= r_total) begin
                            n_idx = '0;
                            if (pos_inc > c_dstart) begin
                                n_phase  = dsvbd_pkg::PH_IDLE;
                                emit     = 1'b1;
                                e_last   = 1'b1;
                                e_status = dsvbd_pkg::ST_OFFSET;
                            end else if (pos_inc == c_dstart) begin
                                n_phase = dsvbd_pkg::PH_DCTRL;
                            end else begin
                                n_phase = dsvbd_pkg::PH_SKIP;
                            end
                        end
                    end
                end

                dsvbd_pkg::PH_SKIP: begin
                    n_pos = pos_inc;
                    if (pos_inc == c_dstart) begin
                        n_phase = dsvbd_pkg::PH_DCTRL;
                    end
                end

                dsvbd_pkg::PH_DDATA: begin
                    n_pos = pos_inc;
                    if (!val_done) begin
                        n_acc = val[23:0];
                        n_biv = r_biv + 2'd1;
                    end else begin
                        n_acc = '0;
                        n_biv = '0;
                        // new hash run restarts from the base doc id
                        n_doc = store_q[SW-1] ? val + r_base : r_doc + val;
                        n_idx = idx_inc;
                        if (r_idx[1:0] == 2'd3) begin
                            n_ctrl = ctrl_q;
                        end
                        emit   = 1'b1;
                        e_hash = store_q[31:0];
                        e_doc  = n_doc;
                        e_last = (16'(idx_inc) >= r_total);
                        if (e_last) begin
                            n_phase = dsvbd_pkg::PH_IDLE;
                        end
                    end
                end

                default: begin
                    n_phase = dsvbd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Reads follow the next item index so data is ready when its bytes arrive
    assign store_raddr = n_idx[AW-1:0];
    assign ctrl_raddr  = CW'((n_idx >> 2) + IW'(1));

    dsvbd_ram #(
        .WIDTH (8),
        .DEPTH (dsvbd_pkg::CTRL_DEPTH)
    ) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (cw_en),
        .i_waddr (ctrl_k[CW-1:0]),
        .i_wdata (i_block_byte),
        .i_raddr (ctrl_raddr),
        .o_rdata (ctrl_q)
    );

    dsvbd_ram #(
        .WIDTH (SW),
        .DEPTH (dsvbd_pkg::MAX_ITEMS)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (sw_en),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata ({(val != 32'd0), h_sum}),
        .i_raddr (store_raddr),
        .o_rdata (store_q)
    );

    // Result register: refilled whenever the input side may move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= in_acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_out_hash   <= e_hash;
            r_out_doc    <= e_doc;
            r_out_last   <= e_last;
            r_out_status <= e_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;
    assign o_doc_id     = r_out_doc;
    assign o_last_item  = r_out_last;
    assign o_status     = 2'(r_out_status);

`ifndef SYNTHESIS
    // Error beats carry zero fields and close the block
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_out_status != dsvbd_pkg::ST_PAIR)
            |-> (o_last_item && o_hash_value == 32'd0 && o_doc_id == 32'd0))
        else $error("error beat with non-zero fields or not last");

    // No partial value is left behind between blocks
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dsvbd_pkg::PH_IDLE || r_phase == dsvbd_pkg::PH_HEADER)
            |-> (r_biv == 2'd0 && r_acc == 24'd0))
        else $error("value assembly not clear outside data phases");

    // Item index stays inside the block while values are read
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dsvbd_pkg::PH_HDATA || r_phase == dsvbd_pkg::PH_DDATA)
            |-> (16'(r_idx) < r_total))
        else $error("item index beyond item count");

    // Byte counter within a value never passes its length code
    a_biv_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dsvbd_pkg::PH_HDATA || r_phase == dsvbd_pkg::PH_DDATA)
            |-> (r_biv <= cur_code))
        else $error("byte count passed the length code");

    // A status beat always ends decoding of the block
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && emit && e_status != dsvbd_pkg::ST_PAIR)
            |=> (r_phase == dsvbd_pkg::PH_IDLE))
        else $error("decoder kept running after a status beat");
`endif

endmodule

`default_nettype wire

@@ tb/sv/delta_stream_vbyte_block_decoder_test.sv @@
`default_nettype none

module delta_stream_vbyte_block_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Block shapes built by the stimulus
    localparam int BLK_GOOD   = 0;
    localparam int BLK_BEHIND = 1;
    localparam int BLK_OVER   = 2;
    localparam int BLK_EMPTY  = 3;
    localparam int BLK_CUT    = 4;

    typedef struct packed {
        logic [7:0] b;
        logic       s;
    } t_beat;

    typedef struct {
        logic [31:0]        hash;
        logic [31:0]        doc;
        logic               last;
        dsvbd_pkg::t_status st;
    } t_pair;

    // Ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [31:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_block_byte  = '0;
    logic        i_block_start = 1'b0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_hash_value;
    logic [31:0] o_doc_id;
    logic        o_last_item;
    logic [1:0]  o_status;

    // Stimulus and scoreboard
    t_beat      byte_q[$];
    t_pair      decoded_q[$];
    logic [7:0] blk[$];

    int errors       = 0;
    int bytes_queued = 0;
    int bytes_sent   = 0;
    int blocks       = 0;
    int pairs_seen   = 0;
    int offset_seen  = 0;
    int count_seen   = 0;
    bit byte_taken   = 1'b0;
    bit no_gaps      = 1'b0;
    bit steady_out   = 1'b0;
    bit hold_req     = 1'b0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;

    // Decoder state mirrored by the predictor
    dsvbd_pkg::t_phase dec_phase;
    logic [15:0] dec_pos, dec_count, dec_doff, dec_idx;
    logic [1:0]  dec_bcnt;
    logic [23:0] dec_acc;
    logic [31:0] dec_hash, dec_docid, dec_base;
    logic [7:0]  dec_codes [dsvbd_pkg::CTRL_DEPTH];
    logic [31:0] dec_hashes [dsvbd_pkg::MAX_ITEMS];
    logic        dec_marks [dsvbd_pkg::MAX_ITEMS];

    delta_stream_vbyte_block_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_block_byte  (i_block_byte),
        .i_block_start (i_block_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hash_value  (o_hash_value),
        .o_doc_id      (o_doc_id),
        .o_last_item   (o_last_item),
        .o_status      (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void clear_block();
        dec_pos   = '0;
        dec_count = '0;
        dec_doff  = '0;
        dec_idx   = '0;
        dec_bcnt  = '0;
        dec_acc   = '0;
        dec_hash  = '0;
        dec_docid = '0;
    endfunction

    function automatic void queue_pair(input logic [31:0] h, input logic [31:0] d,
                                       input logic fin, input dsvbd_pkg::t_status st);
        t_pair p;
        p.hash = h;
        p.doc  = d;
        p.last = fin;
        p.st   = st;
        decoded_q.push_back(p);
    endfunction

    function automatic logic [1:0] len_code(input logic [15:0] idx);
        logic [15:0] k;
        k = idx >> 2;
        if (k >= dsvbd_pkg::CTRL_DEPTH)
            return 2'd0;
        return dec_codes[k][2 * idx[1:0] +: 2];
    endfunction

    // Collects little-endian bytes; true once the value for the current item is whole
    function automatic bit take_value(input logic [7:0] b, output logic [31:0] v);
        int unsigned sh;
        sh = 8 * dec_bcnt;
        v  = '0;
        if (dec_bcnt >= len_code(dec_idx)) begin
            v        = {8'h00, dec_acc} | ({24'h0, b} << sh);
            dec_acc  = '0;
            dec_bcnt = '0;
            return 1'b1;
        end
        dec_acc  = 24'({8'h00, dec_acc} | ({24'h0, b} << sh));
        dec_bcnt = dec_bcnt + 2'd1;
        return 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic s);
        logic [15:0] pos, k;
        logic [31:0] v, h;
        logic        mark, fin;
        if (s) begin
            clear_block();
            dec_phase = dsvbd_pkg::PH_HEADER;
        end
        pos = dec_pos;
        case (dec_phase)
            dsvbd_pkg::PH_HEADER: begin
                dec_pos = pos + 16'd1;
                if (pos == 16'd0) begin
                    dec_count = {8'h00, b};
                end else if (pos == 16'd1) begin
                    dec_count[15:8] = b;
                end else if (pos == 16'd2) begin
                    dec_doff = {8'h00, b};
                end else begin
                    dec_doff[15:8] = b;
                    if (dec_count > dsvbd_pkg::MAX_ITEMS) begin
                        dec_phase = dsvbd_pkg::PH_IDLE;
                        queue_pair(32'd0, 32'd0, 1'b1, dsvbd_pkg::ST_COUNT);
                    end else begin
                        dec_phase = (dec_count == 16'd0) ? dsvbd_pkg::PH_IDLE
                                                         : dsvbd_pkg::PH_HCTRL;
                    end
                end
            end
            dsvbd_pkg::PH_HCTRL, dsvbd_pkg::PH_DCTRL: begin
                k = (dec_phase == dsvbd_pkg::PH_HCTRL)
                    ? pos - 16'(dsvbd_pkg::HEADER_BYTES) : pos - dec_doff;
                if (k < dsvbd_pkg::CTRL_DEPTH)
                    dec_codes[k] = b;
                dec_pos = pos + 16'd1;
                if ({16'd0, k} + 32'd1 >= ({16'd0, dec_count} + 32'd3) / 32'd4) begin
                    dec_phase = (dec_phase == dsvbd_pkg::PH_HCTRL) ? dsvbd_pkg::PH_HDATA
                                                                   : dsvbd_pkg::PH_DDATA;
                    dec_idx   = '0;
                end
            end
            dsvbd_pkg::PH_HDATA: begin
                dec_pos = pos + 16'd1;
                if (take_value(b, v)) begin
                    dec_hash = dec_hash + v;
                    if (dec_idx < dsvbd_pkg::MAX_ITEMS) begin
                        dec_hashes[dec_idx] = dec_hash;
                        dec_marks[dec_idx]  = (v != 32'd0);
                    end
                    dec_idx = dec_idx + 16'd1;
                    if (dec_idx >= dec_count) begin
                        dec_idx = '0;
                        // docid offset must not lie inside the hash stream
                        if (dec_pos > dec_doff) begin
                            dec_phase = dsvbd_pkg::PH_IDLE;
                            queue_pair(32'd0, 32'd0, 1'b1, dsvbd_pkg::ST_OFFSET);
                        end else begin
                            dec_phase = (dec_pos == dec_doff) ? dsvbd_pkg::PH_DCTRL
                                                              : dsvbd_pkg::PH_SKIP;
                        end
                    end
                end
            end
            dsvbd_pkg::PH_SKIP: begin
                dec_pos = pos + 16'd1;
                if (dec_pos == dec_doff)
                    dec_phase = dsvbd_pkg::PH_DCTRL;
            end
            dsvbd_pkg::PH_DDATA: begin
                dec_pos = pos + 16'd1;
                if (take_value(b, v)) begin
                    h    = '0;
                    mark = 1'b0;
                    if (dec_idx < dsvbd_pkg::MAX_ITEMS) begin
                        h    = dec_hashes[dec_idx];
                        mark = dec_marks[dec_idx];
                    end
                    // new hash run restarts from the base doc id
                    dec_docid = mark ? v + dec_base : dec_docid + v;
                    dec_idx   = dec_idx + 16'd1;
                    fin       = (dec_idx >= dec_count);
                    if (fin)
                        dec_phase = dsvbd_pkg::PH_IDLE;
                    queue_pair(h, dec_docid, fin, dsvbd_pkg::ST_PAIR);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put(input logic [7:0] b, input logic s);
        t_beat t;
        t.b = b;
        t.s = s;
        byte_q.push_back(t);
        bytes_queued++;
    endtask

    function automatic logic [31:0] rand_value(input int len);
        logic [31:0] v;
        v = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
        if ($urandom_range(0, 4) == 0)
            v = '0;
        return (len == 4) ? v : v & ((32'd1 << (8 * len)) - 32'd1);
    endfunction

    // Control bytes then data bytes of one stream
    task automatic add_stream(input int n, input bit narrow);
        int          len [dsvbd_pkg::MAX_ITEMS];
        logic [7:0]  c;
        logic [31:0] v;
        for (int k = 0; k < (n + 3) / 4; k++) begin
            c = 8'($urandom);
            for (int j = 0; j < 4; j++) begin
                if (4 * k + j < n) begin
                    len[4 * k + j] = narrow ? 1 : $urandom_range(1, 4);
                    c[2 * j +: 2]  = 2'(len[4 * k + j] - 1);
                end
            end
            blk.push_back(c);
        end
        for (int i = 0; i < n; i++) begin
            v = rand_value(len[i]);
            for (int q = 0; q < len[i]; q++)
                blk.push_back(v[8 * q +: 8]);
        end
    endtask

    task automatic add_block(input int shape, input int n, input int skip, input bit narrow);
        int          hend, cut;
        logic [15:0] cnt, off;
        blk.delete();
        // stray bytes between blocks are ignored by the decoder unless a cut block left it mid-stream
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) put(8'($urandom), 1'b0);
        cnt = 16'(n);
        off = '0;
        if (shape == BLK_OVER) begin
            cnt = 16'($urandom_range(dsvbd_pkg::MAX_ITEMS + 1, 65535));
            off = 16'($urandom);
        end else if (shape == BLK_EMPTY) begin
            cnt = '0;
            off = 16'($urandom);
        end
        blk.push_back(cnt[7:0]);
        blk.push_back(cnt[15:8]);
        blk.push_back(off[7:0]);
        blk.push_back(off[15:8]);
        if (cnt != 16'd0 && cnt <= dsvbd_pkg::MAX_ITEMS) begin
            add_stream(n, narrow);
            hend = blk.size();
            if (shape == BLK_BEHIND) begin
                off = 16'($urandom_range(0, hend - 1));
            end else begin
                off = 16'(hend + skip);
                repeat (skip) blk.push_back(8'($urandom));
                add_stream(n, narrow);
            end
            blk[2] = off[7:0];
            blk[3] = off[15:8];
        end
        // a cut block is abandoned by the next block start
        cut = (shape == BLK_CUT) ? $urandom_range(1, blk.size() - 1) : blk.size();
        for (int i = 0; i < cut; i++)
            put(blk[i], i == 0);
        if (shape != BLK_CUT)
            repeat ($urandom_range(0, 2)) put(8'($urandom), 1'b0);
        blocks++;
    endtask

    task automatic random_phase(input int budget);
        int goal, r, n, skip;
        bit narrow;
        goal = bytes_queued + budget;
        while (bytes_queued < goal) begin
            r      = $urandom_range(0, 99);
            n      = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8)
                   : ($urandom_range(0, 9) < 8) ? $urandom_range(9, 40)
                   : $urandom_range(41, 100);
            skip   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            narrow = ($urandom_range(0, 9) == 0);
            if (r < 68)      add_block(BLK_GOOD, n, skip, narrow);
            else if (r < 76) add_block(BLK_BEHIND, n, 0, narrow);
            else if (r < 82) add_block(BLK_OVER, 0, 0, 1'b0);
            else if (r < 87) add_block(BLK_EMPTY, 0, 0, 1'b0);
            else             add_block(BLK_CUT, n, skip, narrow);
        end
        // leave the decoder idle at the end of the phase
        add_block(BLK_GOOD, $urandom_range(1, 8), 0, 1'b0);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || i_in_valid || decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_base(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= $urandom;
    endtask

    // ---------------------------------------------------------------
    // Byte driver: one beat at a time from byte_q, random gaps (none while no_gaps is set) between beats
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : drive_bytes
        t_beat      cur;
        logic       nv;
        logic [7:0] nb;
        logic       ns;
        nv = i_in_valid;
        nb = i_block_byte;
        ns = i_block_start;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!i_in_valid || byte_taken) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (byte_q.size() > 0) begin
                cur      = byte_q.pop_front();
                nb       = cur.b;
                ns       = cur.s;
                nv       = 1'b1;
                send_gap = pick_gap(no_gaps);
            end
        end
        i_in_valid    <= nv;
        i_block_byte  <= nb;
        i_block_start <= ns;
    end

    // Result receiver: random stalls unless steady_out is set, plus one long hold-off on request
    always @(negedge i_clk) begin : drive_ready
        logic nr;
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
            nr        = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else begin
            nr         = 1'b1;
            stall_left = pick_gap(steady_out);
        end
        i_out_ready <= nr;
    end

    // Monitor: check result beats, then predict from accepted byte beats
    always @(posedge i_clk) begin : watch_ports
        t_pair want;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    report("result with nothing pending", o_hash_value, 32'd0);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_hash_value !== want.hash)
                        report("hash_value", o_hash_value, want.hash);
                    if (o_doc_id !== want.doc)
                        report("doc_id", o_doc_id, want.doc);
                    if (o_last_item !== want.last)
                        report("last_item", {31'd0, o_last_item}, {31'd0, want.last});
                    if (o_status !== want.st)
                        report("status", {30'd0, o_status}, {30'd0, want.st});
                    case (want.st)
                        dsvbd_pkg::ST_OFFSET: offset_seen++;
                        dsvbd_pkg::ST_COUNT:  count_seen++;
                        default:              pairs_seen++;
                    endcase
                end
            end
            if (i_cfg_we)
                dec_base = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_block_byte, i_block_start);
                byte_taken = 1'b1;
                bytes_sent++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        clear_block();
        dec_phase = dsvbd_pkg::PH_IDLE;
        dec_base  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, empty block, both error kinds, wrapping docid
        set_base(32'hFFFF_FFFF);
        put(8'hA5, 1'b0);
        put(8'h00, 1'b1); put(8'h00, 1'b0); put(8'hFF, 1'b0); put(8'hFF, 1'b0);
        put(8'hFF, 1'b1); put(8'hFF, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
        put(8'h01, 1'b1); put(8'h01, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
        put(8'h01, 1'b1); put(8'h00, 1'b0); put(8'h09, 1'b0); put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        repeat (4) put(8'hFF, 1'b0);
        put(8'hFF, 1'b0);
        repeat (4) put(8'hFF, 1'b0);
        put(8'h01, 1'b1); put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
        put(8'h00, 1'b0); put(8'h00, 1'b0);
        put(8'h5A, 1'b0);
        wait_drained();

        // random blocks with idling on both sides
        set_base(32'd0);
        random_phase(60);
        wait_drained();

        // receiver holds off while the sender keeps pushing
        set_base($urandom);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        random_phase(40);
        wait_drained();
        no_gaps = 1'b0;

        // hash stream at full capacity, docid offset behind it
        set_base(32'h8000_0000);
        add_block(BLK_BEHIND, dsvbd_pkg::MAX_ITEMS, 0, 1'b1);
        wait_drained();

        // back-to-back stretch without idling
        set_base($urandom);
        no_gaps    = 1'b1;
        steady_out = 1'b1;
        random_phase(60);
        wait_drained();
        no_gaps    = 1'b0;
        steady_out = 1'b0;

        repeat (8) @(negedge i_clk);
        if (decoded_q.size() != 0)
            report("results never delivered", 32'(decoded_q.size()), 32'd0);
        $display("covered %0d bytes in %0d blocks under 5 base doc id settings",
                 bytes_sent, blocks);
        $display("checked %0d pairs, %0d offset errors, %0d count errors; %0d mismatches",
                 pairs_seen, offset_seen, count_seen, errors);
        if (errors == 0) begin
            $display("PASS delta_stream_vbyte_block_decoder");
        end else begin
            $display("FAIL delta_stream_vbyte_block_decoder");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("FAIL delta_stream_vbyte_block_decoder");
        $finish;
    end

endmodule

`default_nettype wire

@@ delta_stream_vbyte_block_decoder.f @@
rtl/dsvbd_pkg.sv
rtl/dsvbd_ram.sv
rtl/delta_stream_vbyte_block_decoder.sv
tb/sv/delta_stream_vbyte_block_decoder_test.sv
